// ===== design/hed_pkg.sv =====
// shared types, constants and the entity name table for the html entity decoder
`timescale 1ns / 1ps

package hed_pkg;

	localparam int NAME_LETTERS_MAX = 9;
	localparam int NAME_CNT_W = $clog2(NAME_LETTERS_MAX + 1);
	localparam int LETTER_IDX_W = $clog2(NAME_LETTERS_MAX);
	localparam int POS_W = $clog2(NAME_LETTERS_MAX + 2);
	localparam int ACC_W = 16;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_QMARK = 8'h3f;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [ACC_W-1:0] NUM_LO = ACC_W'(32);
	localparam logic [ACC_W-1:0] NUM_HI = ACC_W'(127);

	localparam int NAME_COUNT = 12;
	localparam int NAME_TXT_MAX = 6;

	typedef logic [8*NAME_TXT_MAX-1:0] name_txt_t;

	localparam name_txt_t NAME_TXT [NAME_COUNT] = '{
		"amp", "lt", "gt", "quot", "apos", "nbsp",
		"copy", "reg", "mdash", "ndash", "hellip", "trade"
	};
	localparam int NAME_LEN [NAME_COUNT] = '{3, 2, 2, 4, 4, 4, 4, 3, 5, 5, 6, 5};
	localparam logic [7:0] NAME_CHR [NAME_COUNT] = '{
		8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h20,
		8'h63, 8'h72, 8'h2d, 8'h2d, 8'h2e, 8'h74
	};

	typedef enum logic [2:0] {
		PM_IDLE = 3'd0,
		PM_NAME = 3'd1,
		PM_HASH = 3'd2,
		PM_DEC  = 3'd3,
		PM_HEX  = 3'd4
	} parse_mode_t;

	typedef logic [NAME_LETTERS_MAX-1:0][6:0] letters_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       text_done;
	} out_word_t;

	// one emit job: head byte, then rep_n stored letters, then an optional tail byte
	typedef struct packed {
		logic [7:0]            head;
		letters_t              letters;
		logic [NAME_CNT_W-1:0] rep_n;
		logic                  tail_v;
		logic [7:0]            tail;
		logic                  eot;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} lookup_t;

	function automatic lookup_t name_lookup(letters_t l, logic [NAME_CNT_W-1:0] n);
		lookup_t r;
		logic same;
		r.hit = 1'b0;
		r.ch = CH_AMP;
		for (int k = 0; k < NAME_COUNT; k++) begin
			same = (n == NAME_CNT_W'(NAME_LEN[k]));
			for (int i = 0; i < NAME_TXT_MAX; i++) begin
				if (i < NAME_LEN[k]) begin
					if ({1'b0, l[i]} != NAME_TXT[k][8*(NAME_LEN[k]-1-i) +: 8]) begin
						same = 1'b0;
					end
				end
			end
			if (same && !r.hit) begin
				r.hit = 1'b1;
				r.ch = NAME_CHR[k];
			end
		end
		return r;
	endfunction

endpackage

// ===== design/html_entity_decoder_top.sv =====
// top level of the streaming html entity decoder
`timescale 1ns / 1ps

// usage:
// text words enter on txt_valid/txt_ready/txt_word (in_byte, end_of_text) and
// decoded characters leave on chr_valid/chr_ready/chr_word (out_byte,
// last_of_run, text_done). both channels are valid/ready handshakes.
// the parser takes one word per cycle while its two-entry job queue has room;
// a word that only feeds a pending entity produces nothing.
// each job emits 1 + letters + tail bytes, one byte per cycle from the output
// register when chr_ready allows, so plain text and known entities sustain one
// word per cycle; an unknown entity of n letters replays as up to n + 2 bytes.
// an accepted word is queued as a job, then emitted from the output register.
// reset clears the parser to idle, empties the queue and drops the output.
// when the receiver stalls the output register holds, the queue fills and
// txt_ready falls two jobs later; nothing is lost.
// end_of_text flushes a pending entity; its final character has text_done set.

module html_entity_decoder_top
	import hed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      txt_valid,
	output logic      txt_ready,
	input  in_word_t  txt_word,
	output logic      chr_valid,
	input  logic      chr_ready,
	output out_word_t chr_word
);

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	hed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.txt_valid (txt_valid),
		.txt_ready (txt_ready),
		.txt_word  (txt_word),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	hed_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	hed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.chr_word   (chr_word)
	);

endmodule

// ===== design/hed_front.sv =====
// entity parser: accepts text words, tracks the reference state and issues emit jobs
`timescale 1ns / 1ps

module hed_front
	import hed_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     txt_valid,
	output logic     txt_ready,
	input  in_word_t txt_word,
	input  logic     q_full,
	output logic     push,
	output cmd_t     cmd
);

	parse_mode_t mode_q, mode_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [NAME_CNT_W-1:0] cnt_q, cnt_d;
	letters_t letters_q, lt_d;

	logic [7:0] b;
	logic eot;
	logic accept;
	logic is_letter, is_digit, is_hex;
	logic store;
	logic [NAME_CNT_W-1:0] name_len;
	lookup_t lk;
	logic has;
	logic [3:0] hex_d;
	logic [ACC_W-1:0] acc_x10;

	function automatic logic [7:0] num_char(logic [ACC_W-1:0] v);
		return (v >= NUM_LO && v < NUM_HI) ? v[7:0] : CH_QMARK;
	endfunction

	assign b = txt_word.in_byte;
	assign eot = txt_word.end_of_text;
	assign txt_ready = !q_full;
	assign accept = txt_valid && txt_ready;

	assign is_letter = ((b | CASE_BIT) >= 8'h61) && ((b | CASE_BIT) <= 8'h7a);
	assign is_digit = (b >= 8'h30) && (b <= 8'h39);
	assign is_hex = is_digit || (((b | CASE_BIT) >= 8'h61) && ((b | CASE_BIT) <= 8'h66));
	assign hex_d = is_digit ? b[3:0] : (b[3:0] + 4'd9);
	assign acc_x10 = (acc_q << 3) + (acc_q << 1);

	assign store = (mode_q == PM_NAME) && !(cnt_q == '0 && b == CH_HASH) && is_letter
		&& (cnt_q < NAME_CNT_W'(NAME_LETTERS_MAX));
	assign name_len = store ? (cnt_q + 1'b1) : cnt_q;

	always_comb begin
		lt_d = letters_q;
		if (store) begin
			lt_d[cnt_q[LETTER_IDX_W-1:0]] = b[6:0];
		end
	end

	assign lk = name_lookup(lt_d, name_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PM_IDLE;
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			acc_q <= acc_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			letters_q <= lt_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		acc_d = acc_q;
		cnt_d = cnt_q;
		has = 1'b0;
		cmd.head = b;
		cmd.letters = lt_d;
		cmd.rep_n = '0;
		cmd.tail_v = 1'b0;
		cmd.tail = b;
		cmd.eot = eot;
		unique case (mode_q) inside
			PM_NAME: begin
				if (cnt_q == '0 && b == CH_HASH) begin
					mode_d = PM_HASH;
					acc_d = '0;
				end else if (store) begin
					cnt_d = name_len;
				end else begin
					has = 1'b1;
					cmd.head = lk.ch;
					cmd.rep_n = lk.hit ? '0 : cnt_q;
					mode_d = PM_IDLE;
					cnt_d = '0;
					if (b == CH_SEMI) begin
						cmd.tail_v = !lk.hit;
						cmd.tail = CH_SEMI;
					end else if (b == CH_AMP) begin
						mode_d = PM_NAME;
					end else begin
						cmd.tail_v = 1'b1;
					end
				end
			end
			PM_HASH, PM_DEC, PM_HEX: begin
				if (mode_q == PM_HASH && (b | CASE_BIT) == CH_LOWER_X) begin
					mode_d = PM_HEX;
				end else if (mode_q != PM_HEX && is_digit) begin
					acc_d = acc_x10 + ACC_W'(b[3:0]);
					mode_d = PM_DEC;
				end else if (mode_q == PM_HEX && is_hex) begin
					acc_d = {acc_q[ACC_W-5:0], hex_d};
				end else begin
					has = 1'b1;
					cmd.head = num_char(acc_q);
					mode_d = PM_IDLE;
					acc_d = '0;
					if (b == CH_AMP) begin
						mode_d = PM_NAME;
						cnt_d = '0;
					end else if (b != CH_SEMI) begin
						cmd.tail_v = 1'b1;
					end
				end
			end
			default: begin
				mode_d = PM_IDLE;
				if (b == CH_AMP) begin
					mode_d = PM_NAME;
					cnt_d = '0;
				end else begin
					has = 1'b1;
				end
			end
		endcase

		// flush a pending reference at end of text
		if (eot) begin
			if (mode_d == PM_NAME) begin
				if (has) begin
					cmd.tail_v = 1'b1;
					cmd.tail = CH_AMP;
				end else begin
					cmd.head = lk.ch;
					cmd.rep_n = lk.hit ? '0 : name_len;
				end
				has = 1'b1;
			end else if (mode_d != PM_IDLE) begin
				has = 1'b1;
				cmd.head = num_char(acc_d);
			end
			mode_d = PM_IDLE;
			cnt_d = '0;
			acc_d = '0;
		end
	end

	assign push = accept && has;

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == PM_IDLE |-> (cnt_q == '0 && acc_q == '0))
		else $error("front idle with stale name count or number");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NAME_CNT_W'(NAME_LETTERS_MAX))
		else $error("name count beyond letter store");
`endif

endmodule

// ===== design/hed_queue.sv =====
// short job queue between the parser and the emitter
`timescale 1ns / 1ps

module hed_queue
	import hed_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;

	function automatic logic [CMDQ_PTR_W-1:0] ptr_next(logic [CMDQ_PTR_W-1:0] p);
		return (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid))
		else $error("job queue underflow");
`endif

endmodule

// ===== design/hed_back.sv =====
// emitter: walks each job byte by byte into the output register
`timescale 1ns / 1ps

module hed_back
	import hed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head_cmd,
	output logic      pop,
	output logic      chr_valid,
	input  logic      chr_ready,
	output out_word_t chr_word
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] last_pos;
	logic [POS_W-1:0] pos_m1;
	logic [LETTER_IDX_W-1:0] li;
	logic [7:0] sel_byte;
	logic is_last;
	logic load;
	logic out_valid_q;
	out_word_t out_q;

	assign last_pos = POS_W'(head_cmd.rep_n) + POS_W'(head_cmd.tail_v);
	assign is_last = (pos_q == last_pos);
	assign pos_m1 = pos_q - 1'b1;
	assign li = pos_m1[LETTER_IDX_W-1:0];

	always_comb begin
		if (pos_q == '0) begin
			sel_byte = head_cmd.head;
		end else if (pos_q <= POS_W'(head_cmd.rep_n)) begin
			sel_byte = {1'b0, head_cmd.letters[li]};
		end else begin
			sel_byte = head_cmd.tail;
		end
	end

	assign load = head_valid && (!out_valid_q || chr_ready);
	assign pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q <= is_last ? '0 : pos_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (chr_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= sel_byte;
			out_q.last_of_run <= is_last;
			out_q.text_done <= is_last && head_cmd.eot;
		end
	end

	assign chr_valid = out_valid_q;
	assign chr_word = out_q;

`ifndef SYNTHESIS
	a_pos_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q <= last_pos)
		else $error("emit position past end of job");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && chr_word.text_done |-> chr_word.last_of_run)
		else $error("text done on a word that does not end its run");
`endif

endmodule

// ===== tb/html_entity_decoder_top_tb.sv =====
// self-checking testbench for the html entity decoder: directed and random text against a decoding model
`timescale 1ns / 1ps

module html_entity_decoder_top_tb;
	import hed_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_MAX = 10;
	localparam int TAIL_CYCLES = 20;

	typedef logic [7:0] text_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic txt_valid = 1'b0;
	logic txt_ready;
	in_word_t txt_word = '0;
	logic chr_valid;
	logic chr_ready = 1'b0;
	out_word_t chr_word;

	html_entity_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.txt_valid(txt_valid),
		.txt_ready(txt_ready),
		.txt_word(txt_word),
		.chr_valid(chr_valid),
		.chr_ready(chr_ready),
		.chr_word(chr_word)
	);

	always #5 clk = ~clk;

	// mirror of the parser state
	parse_mode_t mode_m = PM_IDLE;
	logic [ACC_W-1:0] accum_m = '0;
	logic [6:0] letters_m [NAME_LETTERS_MAX];
	int unsigned count_m = 0;

	out_word_t run_chars[$];
	out_word_t chars_due[$];

	string entity_names [12] = '{"amp", "lt", "gt", "quot", "apos", "nbsp",
		"copy", "reg", "mdash", "ndash", "hellip", "trade"};
	logic [7:0] entity_chars [12] = '{"&", "<", ">", 8'h22, 8'h27, " ",
		"c", "r", "-", "-", ".", "t"};
	string hex_digits = "0123456789abcdefABCDEF";

	int mismatches = 0;
	int words_sent = 0;
	int refs_sent = 0;
	int chars_seen = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit tx_gap_en = 1'b0;
	bit rx_stall_en = 1'b0;

	function automatic bit is_letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_hex(logic [7:0] b);
		return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic void put_char(logic [7:0] b);
		out_word_t w;
		w.out_byte = b;
		w.last_of_run = 1'b0;
		w.text_done = 1'b0;
		run_chars.push_back(w);
	endfunction

	function automatic void plain_char(logic [7:0] b);
		if (b == CH_AMP) begin
			mode_m = PM_NAME;
			count_m = 0;
		end else begin
			put_char(b);
		end
	endfunction

	function automatic void close_name(bit semi);
		bit found;
		bit same;
		found = 1'b0;
		for (int k = 0; k < 12; k++) begin
			if (!found && entity_names[k].len() == count_m) begin
				same = 1'b1;
				for (int i = 0; i < count_m; i++) begin
					if (entity_names[k][i] != {1'b0, letters_m[i]}) begin
						same = 1'b0;
					end
				end
				if (same) begin
					put_char(entity_chars[k]);
					found = 1'b1;
				end
			end
		end
		if (!found) begin
			put_char(CH_AMP);
			for (int i = 0; i < count_m; i++) begin
				put_char({1'b0, letters_m[i]});
			end
			if (semi) begin
				put_char(CH_SEMI);
			end
		end
		mode_m = PM_IDLE;
		count_m = 0;
	endfunction

	function automatic void close_number();
		put_char((accum_m >= NUM_LO && accum_m < NUM_HI) ? accum_m[7:0] : CH_QMARK);
		mode_m = PM_IDLE;
		accum_m = '0;
	endfunction

	function automatic void end_number(logic [7:0] b);
		close_number();
		if (b != CH_SEMI) begin
			plain_char(b);
		end
	endfunction

	// works out the characters one accepted word yields and queues them
	function automatic void decode_word(in_word_t w);
		logic [7:0] b;
		int d;
		b = w.in_byte;
		run_chars.delete();
		case (mode_m)
			PM_NAME: begin
				if (count_m == 0 && b == CH_HASH) begin
					mode_m = PM_HASH;
					accum_m = '0;
				end else if (is_letter(b) && count_m < NAME_LETTERS_MAX) begin
					letters_m[count_m] = b[6:0];
					count_m++;
				end else begin
					close_name(b == CH_SEMI);
					if (b != CH_SEMI) begin
						plain_char(b);
					end
				end
			end
			PM_HASH: begin
				if ((b | CASE_BIT) == CH_LOWER_X) begin
					mode_m = PM_HEX;
				end else if (is_digit(b)) begin
					accum_m = ACC_W'(int'(accum_m) * 10 + int'(b) - int'("0"));
					mode_m = PM_DEC;
				end else begin
					end_number(b);
				end
			end
			PM_DEC: begin
				if (is_digit(b)) begin
					accum_m = ACC_W'(int'(accum_m) * 10 + int'(b) - int'("0"));
				end else begin
					end_number(b);
				end
			end
			PM_HEX: begin
				if (is_hex(b)) begin
					d = is_digit(b) ? int'(b) - int'("0") : int'(b | CASE_BIT) - int'("a") + 10;
					accum_m = ACC_W'(int'(accum_m) * 16 + d);
				end else begin
					end_number(b);
				end
			end
			default: begin
				mode_m = PM_IDLE;
				plain_char(b);
			end
		endcase
		if (w.end_of_text) begin
			if (mode_m == PM_NAME) begin
				close_name(1'b0);
			end else if (mode_m == PM_HASH || mode_m == PM_DEC || mode_m == PM_HEX) begin
				close_number();
			end
			mode_m = PM_IDLE;
			count_m = 0;
			accum_m = '0;
		end
		if (run_chars.size() > 0) begin
			run_chars[run_chars.size() - 1].last_of_run = 1'b1;
			run_chars[run_chars.size() - 1].text_done = w.end_of_text;
		end
		foreach (run_chars[i]) begin
			chars_due.push_back(run_chars[i]);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end
		if (r < 95) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [7:0] random_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic text_q_t to_text(string s);
		text_q_t t;
		for (int i = 0; i < s.len(); i++) begin
			t.push_back(s[i]);
		end
		return t;
	endfunction

	// one random chunk of text: mostly references, well-formed or broken, and some noise
	function automatic text_q_t random_text();
		text_q_t t;
		string s;
		int kind;
		int k;
		int r;
		kind = $urandom_range(0, 99);
		if (kind < 20) begin
			repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
			return t;
		end
		if (kind < 30) begin
			repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(32, 126)));
			return t;
		end
		t.push_back(CH_AMP);
		if (kind < 55) begin
			k = $urandom_range(0, 11);
			s = entity_names[k];
			for (int i = 0; i < s.len(); i++) begin
				t.push_back(s[i]);
			end
			if ($urandom_range(0, 4) == 0) begin
				t[$urandom_range(1, s.len())] = random_letter();
			end
		end else if (kind < 80) begin
			t.push_back(CH_HASH);
			if ($urandom_range(0, 1)) begin
				t.push_back($urandom_range(0, 1) ? CH_LOWER_X : (CH_LOWER_X & ~CASE_BIT));
				if ($urandom_range(0, 1)) begin
					s = $sformatf("%0h", $urandom_range(0, 160));
					if ($urandom_range(0, 1)) begin
						s = s.toupper();
					end
				end else begin
					s = "";
					repeat ($urandom_range(0, 6)) begin
						r = $urandom_range(0, hex_digits.len() - 1);
						s = {s, hex_digits.substr(r, r)};
					end
				end
			end else begin
				if ($urandom_range(0, 1)) begin
					s = $sformatf("%0d", $urandom_range(0, 200));
				end else begin
					s = "";
					repeat ($urandom_range(0, 7)) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
				end
			end
			for (int i = 0; i < s.len(); i++) begin
				t.push_back(s[i]);
			end
		end else begin
			repeat ($urandom_range(0, 11)) t.push_back(random_letter());
		end
		r = $urandom_range(0, 9);
		if (r < 5) begin
			t.push_back(CH_SEMI);
		end else if (r < 8) begin
			t.push_back(8'($urandom_range(0, 255)));
		end
		return t;
	endfunction

	task automatic send_word(logic [7:0] b, logic eot);
		in_word_t w;
		w.in_byte = b;
		w.end_of_text = eot;
		if (tx_gap_en && $urandom_range(0, 9) < 3) begin
			txt_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		txt_valid <= 1'b1;
		txt_word <= w;
		do begin
			@(posedge clk);
		end while (!txt_ready);
		decode_word(w);
		words_sent++;
		if (b == CH_AMP) begin
			refs_sent++;
		end
	endtask

	task automatic send_text(text_q_t t, bit eot_last);
		foreach (t[i]) begin
			send_word(t[i], eot_last && i == t.size() - 1);
		end
	endtask

	task automatic wait_drained();
		txt_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (chars_due.size() != 0);
	endtask

	task automatic report_bad(string why, out_word_t want);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("%0t: %s: expected byte %02h last %0b done %0b, got byte %02h last %0b done %0b",
				$realtime, why, want.out_byte, want.last_of_run, want.text_done,
				chr_word.out_byte, chr_word.last_of_run, chr_word.text_done);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && chr_valid && chr_ready) begin
			chars_seen++;
			if (chars_due.size() == 0) begin
				report_bad("character with nothing due", '0);
			end else begin
				want = chars_due.pop_front();
				if (chr_word.out_byte !== want.out_byte ||
					chr_word.last_of_run !== want.last_of_run ||
					chr_word.text_done !== want.text_done) begin
					report_bad("wrong character", want);
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			chr_ready <= 1'b0;
		end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			chr_ready <= 1'b0;
		end else begin
			chr_ready <= 1'b1;
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((txt_valid && txt_ready) || (chr_valid && chr_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d characters due",
				idle_cycles, chars_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_plain_bytes();
		tx_gap_en = 1'b1;
		rx_stall_en = 1'b1;
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
	endtask

	task automatic test_known_name();
		send_text(to_text("&lt;"), 1'b0);
	endtask

	task automatic test_numeric_refs();
		send_text(to_text("&#X7ez"), 1'b0);
		send_text(to_text("&#;"), 1'b0);
	endtask

	task automatic test_unknown_name_at_capacity();
		send_text(to_text("&abcdefghij"), 1'b1);
	endtask

	task automatic test_random_text(int n, bit gaps, bit stalls);
		int stop;
		tx_gap_en = gaps;
		rx_stall_en = stalls;
		stop = words_sent + n;
		while (words_sent < stop) begin
			send_text(random_text(), $urandom_range(0, 9) == 0);
		end
	endtask

	task automatic test_drain_pause();
		tx_gap_en = 1'b1;
		rx_stall_en = 1'b1;
		repeat (4) send_text(random_text(), 1'b0);
		wait_drained();
		send_text(to_text("&#60;&quot"), 1'b1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_bytes();
		test_known_name();
		test_numeric_refs();
		test_unknown_name_at_capacity();
		test_random_text(200, 1'b1, 1'b1);
		test_drain_pause();
		test_random_text(120, 1'b0, 1'b0);
		test_random_text(120, 1'b0, 1'b1);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d text words (%0d opening a reference), checked %0d characters",
			words_sent, refs_sent, chars_seen);
		$display("covered corner bytes, named, numeric and unknown references, full-rate and stalled runs");
		if (mismatches == 0 && chars_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
